>>> design/reng_pkg.sv
// Shared types, constants and the control store of the Eddington number unit.
package reng_pkg;

   localparam int MAX_LEN = 1024;
   localparam int LEN_W   = $clog2(MAX_LEN);
   localparam int BIN_W   = 16;
   localparam int SUM_W   = 20;
   localparam int NEED_W  = 21;
   localparam int STEP_W  = 4;

   typedef logic [LEN_W-1:0]  addr_type;
   typedef logic [BIN_W-1:0]  bin_type;
   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [STEP_W-1:0] step_type;

   localparam addr_type LAST_BIN = addr_type'(MAX_LEN - 1);
   localparam bin_type  BIN_MAX  = '1;
   localparam sum_type  SUM_MAX  = '1;

   // program steps
   localparam step_type S_CLR  = 4'd0;
   localparam step_type S_IDLE = 4'd1;
   localparam step_type S_DISP = 4'd2;
   localparam step_type S_R1   = 4'd3;
   localparam step_type S_R2   = 4'd4;
   localparam step_type S_R3   = 4'd5;
   localparam step_type S_R4   = 4'd6;
   localparam step_type S_Q1   = 4'd7;
   localparam step_type S_Q2   = 4'd8;
   localparam step_type S_EMIT = 4'd9;
   localparam step_type S_HOLD = 4'd10;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_NO_REQ,
      C_QUERY,
      C_SHORT,
      C_NO_CARRY,
      C_MORE_SCAN,
      C_MORE_CLR,
      C_OUT_FREE
   } cond_type;

   typedef enum logic [1:0] {
      A_LEN,
      A_NEXT,
      A_EDD,
      A_IDX
   } asel_type;

   typedef enum logic {
      W_INC,
      W_ZERO
   } wsel_type;

   typedef struct packed {
      cond_type cond;
      step_type target;
      logic     rd;
      logic     wr;
      asel_type asel;
      wsel_type wsel;
      logic     inc_above;
      logic     inc_edd;
      logic     sub_above;
      logic     acc;
      logic     idx_adv;
      logic     emit;
   } ctrl_type;

   localparam ctrl_type NOP = '{
      cond: C_ALWAYS, target: S_IDLE, rd: 1'b0, wr: 1'b0, asel: A_LEN, wsel: W_ZERO,
      inc_above: 1'b0, inc_edd: 1'b0, sub_above: 1'b0, acc: 1'b0, idx_adv: 1'b0,
      emit: 1'b0};

   // conditional jump to target when cond holds, else fall through to step + 1
   function automatic ctrl_type ucode(step_type step);
      ctrl_type c;
      c = NOP;
      unique case (step)
         S_CLR: begin
            c.cond = C_MORE_CLR; c.target = S_CLR;
            c.wr = 1'b1; c.asel = A_IDX; c.wsel = W_ZERO; c.idx_adv = 1'b1;
         end
         S_IDLE: begin
            c.cond = C_NO_REQ; c.target = S_IDLE;
         end
         S_DISP: begin
            c.cond = C_QUERY; c.target = S_Q1;
         end
         S_R1: begin
            c.cond = C_SHORT; c.target = S_EMIT;
            c.rd = 1'b1; c.asel = A_LEN;
         end
         S_R2: begin
            c.cond = C_NO_CARRY; c.target = S_EMIT;
            c.wr = 1'b1; c.asel = A_LEN; c.wsel = W_INC; c.inc_above = 1'b1;
         end
         S_R3: begin
            c.cond = C_MORE_CLR; c.target = S_R4;
            c.cond = C_ALWAYS;
            c.rd = 1'b1; c.asel = A_NEXT; c.inc_edd = 1'b1;
         end
         S_R4: begin
            c.cond = C_ALWAYS; c.target = S_EMIT;
            c.wr = 1'b1; c.asel = A_EDD; c.wsel = W_ZERO; c.sub_above = 1'b1;
         end
         S_Q1: begin
            c.cond = C_ALWAYS; c.target = S_Q2;
            c.rd = 1'b1; c.asel = A_IDX; c.idx_adv = 1'b1;
         end
         S_Q2: begin
            c.cond = C_MORE_SCAN; c.target = S_Q2;
            c.rd = 1'b1; c.asel = A_IDX; c.idx_adv = 1'b1; c.acc = 1'b1;
         end
         S_EMIT: begin
            c.cond = C_OUT_FREE; c.target = S_IDLE; c.emit = 1'b1;
         end
         S_HOLD: begin
            c.cond = C_ALWAYS; c.target = S_EMIT;
         end
         default: c = NOP;
      endcase
      return c;
   endfunction

endpackage

>>> design/reng_hist_ram.sv
// Ride length histogram memory: one write port, one registered read port.
module reng_hist_ram (
   input  logic              clock,
   input  logic              rd_en,
   input  reng_pkg::addr_type rd_addr,
   output reng_pkg::bin_type  rd_data,
   input  logic              wr_en,
   input  reng_pkg::addr_type wr_addr,
   input  reng_pkg::bin_type  wr_data
);
   import reng_pkg::*;

   bin_type mem [MAX_LEN];
   bin_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/running_eddington_number_unit.sv
// Running Eddington number unit: microcoded sequencer over a histogram memory.
//
//  channel | dir | fields (tdata/tuser, low bit first)
//  req_    | in  | tuser: req_type; tdata: ride_length, target_value
//  rsp_    | out | tdata: eddington_now, above_count, rides_needed
//
// Record: steps R1 to R4, exiting early to EMIT from R1 or R2 (one histogram access in each).
// Query: one bin read per cycle, from bin target_value up to the last bin.
// After reset a clearing pass zeroes every histogram bin; req_tready is low meanwhile.
// A finished result waits in the output register; the next beat is taken meanwhile.
module running_eddington_number_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [9:0] ride_length, [19:10] target_value
   input  logic        req_tuser,  // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // [9:0] eddington_now, [19:10] above_count,
                                   // [40:20] rides_needed
);
   import reng_pkg::*;

   step_type  pc_ff, pc_in;
   ctrl_type  ctrl;
   logic      cond_hit;
   logic      accept;
   logic      out_free;
   logic      load_out;

   addr_type  len_ff, target_ff, edd_ff, edd_in, above_ff, above_in;
   addr_type  idx_ff, idx_in;
   logic      is_query_ff;
   logic      last_ff, last_in;
   sum_type   sum_ff, sum_in;
   logic [SUM_W:0] sum_wide;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [47:0]      rsp_data_ff;
   logic [NEED_W-1:0] needed;

   addr_type  mem_addr;
   bin_type   rd_data;
   bin_type   wr_data;
   bin_type   bin_inc;
   addr_type  above_sub;

   assign ctrl     = ucode(pc_ff);
   assign accept   = (pc_ff == S_IDLE) && req_tvalid;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load_out = ctrl.emit && out_free;

   always_comb begin
      case (ctrl.cond)
         C_ALWAYS:    cond_hit = 1'b1;
         C_NO_REQ:    cond_hit = !req_tvalid;
         C_QUERY:     cond_hit = is_query_ff;
         C_SHORT:     cond_hit = len_ff <= edd_ff;
         C_NO_CARRY:  cond_hit = ({1'b0, above_ff} + 1'b1) <= {1'b0, edd_ff};
         C_MORE_SCAN: cond_hit = !last_ff;
         C_MORE_CLR:  cond_hit = idx_ff != LAST_BIN;
         C_OUT_FREE:  cond_hit = out_free;
         default:     cond_hit = 1'b0;
      endcase
   end

   assign pc_in = cond_hit ? ctrl.target : step_type'(pc_ff + 1'b1);

   always_comb begin
      unique case (ctrl.asel)
         A_LEN:   mem_addr = len_ff;
         A_NEXT:  mem_addr = addr_type'(edd_ff + 1'b1);
         A_EDD:   mem_addr = edd_ff;
         A_IDX:   mem_addr = idx_ff;
         default: mem_addr = len_ff;
      endcase
   end

   assign bin_inc = (rd_data == BIN_MAX) ? rd_data : bin_type'(rd_data + 1'b1);
   assign wr_data = (ctrl.wsel == W_INC) ? bin_inc : '0;

   assign above_sub = (rd_data > bin_type'(above_ff)) ? '0
                    : addr_type'(bin_type'(above_ff) - rd_data);

   always_comb begin
      above_in = above_ff;
      if (ctrl.inc_above) begin
         above_in = addr_type'(above_ff + 1'b1);
      end else if (ctrl.sub_above) begin
         above_in = above_sub;
      end
   end

   assign edd_in = ctrl.inc_edd ? addr_type'(edd_ff + 1'b1) : edd_ff;

   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(rd_data);

   always_comb begin
      sum_in = sum_ff;
      if (accept) begin
         sum_in = '0;
      end else if (ctrl.acc) begin
         sum_in = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];
      end
   end

   always_comb begin
      idx_in  = idx_ff;
      last_in = last_ff;
      if (accept) begin
         idx_in = req_tdata[19:10];
      end else if (ctrl.idx_adv) begin
         idx_in  = addr_type'(idx_ff + 1'b1);
         last_in = idx_ff == LAST_BIN;
      end
   end

   assign needed = is_query_ff
                 ? NEED_W'({{(NEED_W-LEN_W){1'b0}}, target_ff} - {1'b0, sum_ff})
                 : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= S_CLR;
         idx_ff       <= '0;
         last_ff      <= 1'b0;
         edd_ff       <= '0;
         above_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
         edd_ff       <= edd_in;
         above_ff     <= above_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (accept) begin
         len_ff      <= req_tdata[9:0];
         target_ff   <= req_tdata[19:10];
         is_query_ff <= req_tuser;
      end
      if (load_out) begin
         rsp_data_ff <= {7'b0, needed, above_ff, edd_ff};
      end
   end

   reng_hist_ram u_hist (
      .clock   (clock),
      .rd_en   (ctrl.rd),
      .rd_addr (mem_addr),
      .rd_data (rd_data),
      .wr_en   (ctrl.wr),
      .wr_addr (mem_addr),
      .wr_data (wr_data)
   );

   assign req_tready = pc_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> verif/running_eddington_number_unit_tb.sv
// Self-checking stream testbench for the running Eddington number unit.
`timescale 1ns / 1ps

module running_eddington_number_unit_tb;
   import reng_pkg::*;

   localparam logic REQ_RIDE     = 1'b0;
   localparam logic REQ_QUERY    = 1'b1;
   localparam int   RANDOM_ITEMS = 1330;
   localparam int   QUIET_ITEMS  = 150;
   localparam int   DRAIN_CYCLES = 32;
   localparam int   CYCLE_LIMIT  = 6000000;

   typedef struct {
      logic [LEN_W-1:0]  eddington_now;
      logic [LEN_W-1:0]  above_count;
      logic [NEED_W-1:0] rides_needed;
   } tally_type;

   // running model of the ride histogram; one expected tally per accepted beat
   class eddington_tracker;
      int unsigned edd_q;
      int unsigned above_q;
      bin_type     hist_q [MAX_LEN];
      tally_type   expected_q [$];
      int          errors;

      function new();
         edd_q   = 0;
         above_q = 0;
         errors  = 0;
         foreach (hist_q[i]) hist_q[i] = '0;
      endfunction

      function void note_request(logic kind, logic [LEN_W-1:0] len_in, logic [LEN_W-1:0] tgt);
         tally_type   t;
         int unsigned len;
         int unsigned bin;
         int unsigned bin_sum;
         t.rides_needed = '0;
         if (kind == REQ_RIDE) begin
            len = len_in;
            if (len > LAST_BIN) len = LAST_BIN;
            if (len > edd_q) begin
               above_q++;
               if (hist_q[len] != BIN_MAX) hist_q[len]++;
               if (above_q > edd_q) begin
                  edd_q++;
                  bin = edd_q;
                  if (bin < MAX_LEN) begin
                     if (hist_q[bin] > above_q) above_q = 0;
                     else above_q -= hist_q[bin];
                     hist_q[bin] = '0;
                  end
               end
            end
         end else begin
            bin_sum = 0;
            for (int i = tgt; i < MAX_LEN; i++) begin
               bin_sum += hist_q[i];
               if (bin_sum > SUM_MAX) bin_sum = SUM_MAX;
            end
            t.rides_needed = NEED_W'(tgt - bin_sum);
         end
         t.eddington_now = edd_q[LEN_W-1:0];
         t.above_count   = above_q[LEN_W-1:0];
         expected_q.insert(expected_q.size(), t);
      endfunction

      function void check_result(logic [47:0] beat);
         tally_type want;
         if (expected_q.size() == 0) begin
            $error("result beat with no request pending");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (beat[9:0] !== want.eddington_now) begin
            $error("eddington_now: expected %0d, got %0d", want.eddington_now, beat[9:0]);
            errors++;
         end
         if (beat[19:10] !== want.above_count) begin
            $error("above_count: expected %0d, got %0d", want.above_count, beat[19:10]);
            errors++;
         end
         if (beat[40:20] !== want.rides_needed) begin
            $error("rides_needed: expected %0d, got %0d",
                   $signed(want.rides_needed), $signed(beat[40:20]));
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   eddington_tracker tracker = new();
   bit               quiet_tail = 1'b0;
   int               stall_left = 0;
   int               cycles     = 0;

   running_eddington_number_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.note_request(req_tuser, req_tdata[9:0], req_tdata[19:10]);
         if (rsp_tvalid && rsp_tready)
            tracker.check_result(rsp_tdata);
      end
   end

   // result-side backpressure
   initial begin
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_beat(logic kind, logic [LEN_W-1:0] len, logic [LEN_W-1:0] tgt);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, tgt, len};
      do @(posedge clock); while (!req_tready);
   endtask

   // mostly rides just above E so the count keeps climbing and bins get reclaimed
   function automatic logic [LEN_W-1:0] pick_length(int unsigned e);
      int unsigned r;
      int unsigned v;
      r = $urandom_range(0, 99);
      if (r < 60) v = e + $urandom_range(1, 8);
      else if (r < 75) v = $urandom_range(0, e);
      else if (r < 88) v = $urandom_range(0, LAST_BIN);
      else if (r < 95) v = e + 1;
      else v = LAST_BIN;
      if (v > LAST_BIN) v = LAST_BIN;
      return v[LEN_W-1:0];
   endfunction

   function automatic logic [LEN_W-1:0] pick_target(int unsigned e);
      int unsigned r;
      int unsigned v;
      r = $urandom_range(0, 99);
      if (r < 50) v = e + $urandom_range(0, 10) - ((e > 5) ? 5 : e);
      else if (r < 80) v = $urandom_range(0, LAST_BIN);
      else if (r < 90) v = 0;
      else v = LAST_BIN;
      if (v > LAST_BIN) v = LAST_BIN;
      return v[LEN_W-1:0];
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty histogram, then build E step by step
      send_beat(REQ_QUERY, 10'h3FF, 10'd0);
      send_beat(REQ_QUERY, 10'h000, LAST_BIN);
      send_beat(REQ_RIDE,  10'd0,   10'h3FF);
      send_beat(REQ_RIDE,  10'h3FF, 10'h000);
      send_beat(REQ_RIDE,  10'h3FF, 10'h3FF);
      send_beat(REQ_RIDE,  10'd1,   10'h000);
      send_beat(REQ_RIDE,  10'd3,   10'h155);
      send_beat(REQ_RIDE,  10'd3,   10'h2AA);
      send_beat(REQ_RIDE,  10'd512, 10'h000);
      send_beat(REQ_QUERY, 10'h3FF, 10'd3);
      send_beat(REQ_QUERY, 10'h3FF, 10'd4);
      send_beat(REQ_QUERY, 10'h155, 10'd0);
      send_beat(REQ_RIDE,  10'd4,   10'h000);
      send_beat(REQ_RIDE,  10'd4,   10'h3FF);
      send_beat(REQ_RIDE,  10'd5,   10'h000);
      send_beat(REQ_RIDE,  10'h2AA, 10'h155);
      send_beat(REQ_RIDE,  10'h155, 10'h2AA);
      send_beat(REQ_QUERY, 10'h000, 10'h2AA);
      send_beat(REQ_QUERY, 10'h3FF, 10'h155);
      send_beat(REQ_QUERY, 10'h000, 10'd512);
      send_beat(REQ_RIDE,  10'h3FF, 10'h3FF);
      send_beat(REQ_QUERY, 10'h2AA, LAST_BIN);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet_tail = (n >= RANDOM_ITEMS - QUIET_ITEMS);
         if ($urandom_range(0, 99) < 9)
            send_beat(REQ_QUERY, LEN_W'($urandom_range(0, LAST_BIN)),
                      pick_target(tracker.edd_q));
         else
            send_beat(REQ_RIDE, pick_length(tracker.edd_q),
                      LEN_W'($urandom_range(0, LAST_BIN)));
      end
      req_tvalid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
